[rtl/core/assert_macros.svh]
// assertion macros for the bracket checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bracket checker assertion failed");

// property checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bracket checker assertion failed");

`endif

[rtl/core/bbc_pkg.sv]
// shared types, constants and helpers for the bracket balance checker
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int POS_WIDTH   = 16;
    localparam int FIELD_POS_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS    = 2 + 3 * FIELD_POS_W + 8 + 8;
    localparam int TDATA_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - OUT_BITS;

    localparam logic [POS_WIDTH-1:0] POS_MAX   = '1;
    localparam logic [CNT_W-1:0]     STACK_FULL = CNT_W'(STACK_DEPTH);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam logic [1:0] BR_PAREN = 2'd0;
    localparam logic [1:0] BR_BRACK = 2'd1;
    localparam logic [1:0] BR_BRACE = 2'd2;

    localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
    localparam logic [1:0] ERR_MISMATCH   = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED   = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           code;
        logic [7:0]           ch;
        logic [POS_WIDTH-1:0] line;
        logic [POS_WIDTH-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [1:0]           code;
        logic [POS_WIDTH-1:0] line;
        logic [POS_WIDTH-1:0] col;
    } entry_t;

    function automatic logic [7:0] opener_byte(input logic [1:0] t);
        logic [7:0] b;
        case (t)
            BR_BRACK: b = CH_LBRACK;
            BR_BRACE: b = CH_LBRACE;
            default:  b = CH_LPAREN;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/bbc_queue.sv]
// short command queue between the scanner and the stack engine
module bbc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bbc_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output bbc_pkg::cmd_t  head_cmd,
    output bbc_pkg::qstat_t stat
);

    bbc_pkg::cmd_t                   slot_reg [bbc_pkg::QUEUE_DEPTH];
    logic [bbc_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bbc_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bbc_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign stat.full  = (cnt_reg == bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bbc_pkg::QUEUE_AW'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bbc_pkg::QUEUE_AW'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/bbc_front.sv]
// scanner: tracks position, skips comments and strings, classifies brackets
module bbc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // ch
    input  logic            s_tuser,   // kind
    input  bbc_pkg::qstat_t q_stat,
    output logic            q_push,
    output bbc_pkg::cmd_t   q_cmd
);

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_SLASH   = 4'b0010,
        MODE_COMMENT = 4'b0100,
        MODE_STRING  = 4'b1000
    } scan_mode_t;

    scan_mode_t                      mode_reg, mode_next;
    logic [bbc_pkg::POS_WIDTH-1:0]   line_reg, line_next;
    logic [bbc_pkg::POS_WIDTH-1:0]   col_reg, col_next;
    logic                            single_reg, single_next;
    logic                            esc_reg, esc_next;
    logic [bbc_pkg::POS_WIDTH-1:0]   col_inc;
    logic                            accept;
    logic                            counted;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && !q_stat.full;
    assign col_inc  = (col_reg < bbc_pkg::POS_MAX) ? col_reg + 1'b1 : col_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        single_next = single_reg;
        esc_next    = esc_reg;
        counted     = 1'b0;
        q_push      = 1'b0;
        q_cmd.op    = bbc_pkg::OP_PUSH;
        q_cmd.code  = bbc_pkg::BR_PAREN;
        q_cmd.ch    = s_tdata;
        q_cmd.line  = line_reg;
        q_cmd.col   = col_inc;

        if (accept && s_tuser)
        begin
            // end of text: hand the flush to the back end, restart scanning
            q_push      = 1'b1;
            q_cmd.op    = bbc_pkg::OP_FLUSH;
            mode_next   = MODE_NORMAL;
            line_next   = bbc_pkg::POS_WIDTH'(1);
            col_next    = '0;
            single_next = 1'b0;
            esc_next    = 1'b0;
        end
        else if (accept)
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (s_tdata == bbc_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        counted = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    counted = (s_tdata == bbc_pkg::CH_NL);
                end
                MODE_STRING:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (s_tdata == bbc_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (s_tdata == (single_reg ? bbc_pkg::CH_SQUOTE : bbc_pkg::CH_DQUOTE))
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                default:
                begin
                    counted = 1'b1;
                end
            endcase

            if (counted)
            begin
                col_next  = col_inc;
                mode_next = MODE_NORMAL;
                case (s_tdata)
                    bbc_pkg::CH_NL:
                    begin
                        line_next = (line_reg < bbc_pkg::POS_MAX) ? line_reg + 1'b1 : line_reg;
                        col_next  = '0;
                    end
                    bbc_pkg::CH_SLASH:
                    begin
                        mode_next = MODE_SLASH;
                    end
                    bbc_pkg::CH_DQUOTE, bbc_pkg::CH_SQUOTE:
                    begin
                        mode_next   = MODE_STRING;
                        single_next = (s_tdata == bbc_pkg::CH_SQUOTE);
                        esc_next    = 1'b0;
                    end
                    bbc_pkg::CH_LPAREN, bbc_pkg::CH_LBRACK, bbc_pkg::CH_LBRACE:
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = bbc_pkg::OP_PUSH;
                        q_cmd.code = (s_tdata == bbc_pkg::CH_LPAREN) ? bbc_pkg::BR_PAREN :
                                     (s_tdata == bbc_pkg::CH_LBRACK) ? bbc_pkg::BR_BRACK :
                                                                       bbc_pkg::BR_BRACE;
                    end
                    bbc_pkg::CH_RPAREN, bbc_pkg::CH_RBRACK, bbc_pkg::CH_RBRACE:
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = bbc_pkg::OP_CLOSE;
                        q_cmd.code = (s_tdata == bbc_pkg::CH_RPAREN) ? bbc_pkg::BR_PAREN :
                                     (s_tdata == bbc_pkg::CH_RBRACK) ? bbc_pkg::BR_BRACK :
                                                                       bbc_pkg::BR_BRACE;
                    end
                    default:
                    begin
                        mode_next = MODE_NORMAL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            line_reg   <= bbc_pkg::POS_WIDTH'(1);
            col_reg    <= '0;
            single_reg <= 1'b0;
            esc_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            single_reg <= single_next;
            esc_reg    <= esc_next;
        end
    end

endmodule

[rtl/core/bbc_back.sv]
// stack engine: bracket stack in memory, closer checks, end-of-text flush
module bbc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbc_pkg::cmd_t                q_cmd,
    input  bbc_pkg::qstat_t              q_stat,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // error_kind, err_line, err_column, found_char, open_char, open_line, zero pad
    output logic [bbc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLOSE = 3'b010,
        ST_FLUSH = 3'b100
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic [bbc_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    bbc_pkg::entry_t                    stack_mem [bbc_pkg::STACK_DEPTH];
    bbc_pkg::entry_t                    rd_data_reg;
    bbc_pkg::cmd_t                      cur_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [1:0]                         out_kind_reg;
    logic [bbc_pkg::POS_WIDTH-1:0]      out_line_reg, out_col_reg, out_oline_reg;
    logic [7:0]                         out_found_reg, out_open_reg;
    logic                               out_last_reg;

    logic                               out_ok;
    logic                               mem_we, rd_en, cur_load, emit;
    logic [bbc_pkg::CNT_W-1:0]          top_cnt, below_cnt;
    logic [bbc_pkg::STACK_AW-1:0]       rd_addr, wr_addr;
    logic [1:0]                         emit_kind;
    logic [bbc_pkg::POS_WIDTH-1:0]      emit_line, emit_col, emit_oline;
    logic [7:0]                         emit_found, emit_open;
    logic                               emit_last;

    assign out_ok    = !out_valid_reg || m_tready;
    assign top_cnt   = cnt_reg - 1'b1;
    assign below_cnt = cnt_reg - bbc_pkg::CNT_W'(2);
    assign wr_addr   = cnt_reg[bbc_pkg::STACK_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = top_cnt[bbc_pkg::STACK_AW-1:0];
        cur_load   = 1'b0;
        emit       = 1'b0;
        emit_kind  = bbc_pkg::ERR_UNEXPECTED;
        emit_line  = q_cmd.line;
        emit_col   = q_cmd.col;
        emit_found = q_cmd.ch;
        emit_open  = '0;
        emit_oline = '0;
        emit_last  = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (q_cmd.op)
                        bbc_pkg::OP_PUSH:
                        begin
                            q_pop = 1'b1;
                            // opener beyond capacity is dropped
                            if (cnt_reg != bbc_pkg::STACK_FULL)
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        bbc_pkg::OP_CLOSE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                if (out_ok)
                                begin
                                    q_pop = 1'b1;
                                    emit  = 1'b1;
                                end
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                rd_en      = 1'b1;
                                cur_load   = 1'b1;
                                state_next = ST_CLOSE;
                            end
                        end
                        bbc_pkg::OP_FLUSH:
                        begin
                            q_pop = 1'b1;
                            if (cnt_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLOSE:
            begin
                emit_kind  = bbc_pkg::ERR_MISMATCH;
                emit_line  = cur_reg.line;
                emit_col   = cur_reg.col;
                emit_found = cur_reg.ch;
                emit_open  = bbc_pkg::opener_byte(rd_data_reg.code);
                emit_oline = rd_data_reg.line;
                if (rd_data_reg.code != cur_reg.code)
                begin
                    if (out_ok)
                    begin
                        emit       = 1'b1;
                        cnt_next   = top_cnt;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = top_cnt;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                emit_kind  = bbc_pkg::ERR_UNCLOSED;
                emit_line  = rd_data_reg.line;
                emit_col   = rd_data_reg.col;
                emit_found = bbc_pkg::opener_byte(rd_data_reg.code);
                emit_open  = bbc_pkg::opener_byte(rd_data_reg.code);
                emit_last  = (cnt_reg == bbc_pkg::CNT_W'(1));
                if (out_ok)
                begin
                    emit     = 1'b1;
                    cnt_next = top_cnt;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry down while this report goes out
                        rd_en   = 1'b1;
                        rd_addr = below_cnt[bbc_pkg::STACK_AW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= '{code: q_cmd.code, line: q_cmd.line, col: q_cmd.col};
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= q_cmd;
        end
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_line_reg  <= emit_line;
            out_col_reg   <= emit_col;
            out_found_reg <= emit_found;
            out_open_reg  <= emit_open;
            out_oline_reg <= emit_oline;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{bbc_pkg::PAD_W{1'b0}},
                       bbc_pkg::FIELD_POS_W'(out_oline_reg),
                       out_open_reg,
                       out_found_reg,
                       bbc_pkg::FIELD_POS_W'(out_col_reg),
                       bbc_pkg::FIELD_POS_W'(out_line_reg),
                       out_kind_reg};

endmodule

[rtl/core/bracket_balance_checker_top.sv]
// closer report: command queue, then output register (empty stack); a mismatch adds the stack read
// throughput: one byte per cycle unless the queue is full; a closer's stack read holds the engine
// end of text: a stack read, then one unclosed report per cycle while the output is not stalled
// the command queue (4 words) lets the scanner keep taking bytes while the stack engine works
// reset: rst_n low clears scanner, queue, stack count and output valid; the stack memory is not cleared
module bracket_balance_checker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // ch
    input  logic                         s_tuser,   // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // error_kind, err_line, err_column, found_char, open_char, open_line, zero pad
    output logic [bbc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tlast    // last
);

    bbc_pkg::cmd_t   push_cmd;
    bbc_pkg::cmd_t   head_cmd;
    bbc_pkg::qstat_t q_stat;
    logic            q_push;
    logic            q_pop;

    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    bbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    bbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (head_cmd),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/bbc_checker.sv]
// port-level checks on the bracket balance checker output stream
`include "assert_macros.svh"

module bbc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [bbc_pkg::TDATA_W-1:0]  m_tdata,
    input  logic                         m_tlast
);

    logic [1:0]  err_kind;
    logic [15:0] err_line;
    logic [7:0]  found_char;
    logic [7:0]  open_char;
    logic [15:0] open_line;
    logic        stalled;
    logic        is_closer;
    logic        is_unclosed;
    logic        unclosed_ok;

    assign err_kind    = m_tdata[1:0];
    assign err_line    = m_tdata[17:2];
    assign found_char  = m_tdata[41:34];
    assign open_char   = m_tdata[49:42];
    assign open_line   = m_tdata[65:50];
    assign stalled     = m_tvalid && !m_tready;
    assign is_closer   = (err_kind == bbc_pkg::ERR_UNEXPECTED) ||
                         (err_kind == bbc_pkg::ERR_MISMATCH);
    assign is_unclosed = (err_kind == bbc_pkg::ERR_UNCLOSED);
    assign unclosed_ok = (found_char == open_char) && (open_line == 16'd0);

    // the asynchronous reset clears the output valid register
    `CHK_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_tvalid)

    `CHK_ASSERT(a_stall_holds, clk, rst_n, stalled |=> m_tvalid && $stable({m_tdata, m_tlast}))

    // closer reports are the only report of their byte
    `CHK_ASSERT(a_closer_last, clk, rst_n, m_tvalid && is_closer |-> m_tlast)

    // unclosed reports carry the opener twice and no opener line
    `CHK_ASSERT(a_unclosed_fields, clk, rst_n, m_tvalid && is_unclosed |-> unclosed_ok)

    `CHK_ASSERT(a_line_nonzero, clk, rst_n, m_tvalid |-> err_line != 16'd0)

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (.*);

[test/tb_top.sv]
// stream testbench for the bracket balance checker, self-checking against its own scan predictor
module tb_top;
    import bbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 280;

    typedef enum logic [1:0] {
        SCAN_NORMAL  = 2'd0,
        SCAN_SLASH   = 2'd1,
        SCAN_COMMENT = 2'd2,
        SCAN_STRING  = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  found;
        logic [7:0]  opener;
        logic [15:0] oline;
        logic        last;
    } report_t;

    typedef struct {
        logic    eot;
        logic [7:0] ch;
        bit      typed;
        report_t want;
    } dir_row_t;

    localparam report_t NO_REPORT = '0;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tuser  = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic m_tlast;

    bracket_balance_checker_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // scanner state as the block should hold it
    logic [1:0]  stk_type [STACK_DEPTH];
    logic [15:0] stk_line [STACK_DEPTH];
    logic [15:0] stk_col  [STACK_DEPTH];
    int          depth       = 0;
    logic [15:0] line_now    = 16'd1;
    logic [15:0] col_now     = 16'd0;
    scan_mode_t  mode        = SCAN_NORMAL;
    logic        quote_single = 1'b0;
    logic        esc_pending = 1'b0;

    logic [7:0] opener_chars [3] = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
    logic [7:0] closer_chars [3] = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};

    report_t step_reports [$];
    report_t due_reports  [$];

    bit  no_idle       = 1'b0;
    int  sent_items    = 0;
    int  eot_items     = 0;
    int  seen_reports  = 0;
    int  kind_seen [3] = '{0, 0, 0};
    int  mismatches    = 0;
    int  quiet_cycles  = 0;

    dir_row_t directed_rows [26] = '{
        '{1'b0, CH_RPAREN, 1'b1,
          '{ERR_UNEXPECTED, 16'd1, 16'd1, CH_RPAREN, 8'h00, 16'd0, 1'b1}},
        '{1'b0, CH_LPAREN, 1'b0, NO_REPORT},
        '{1'b0, CH_RBRACK, 1'b1,
          '{ERR_MISMATCH, 16'd1, 16'd3, CH_RBRACK, CH_LPAREN, 16'd1, 1'b1}},
        '{1'b0, CH_NL,     1'b0, NO_REPORT},
        '{1'b0, CH_LBRACE, 1'b0, NO_REPORT},
        '{1'b0, CH_LBRACK, 1'b0, NO_REPORT},
        '{1'b0, CH_SLASH,  1'b0, NO_REPORT},
        '{1'b0, CH_SLASH,  1'b0, NO_REPORT},
        '{1'b0, CH_RPAREN, 1'b0, NO_REPORT},  // inside line comment
        '{1'b0, CH_NL,     1'b0, NO_REPORT},
        '{1'b0, CH_DQUOTE, 1'b0, NO_REPORT},
        '{1'b0, CH_BSLASH, 1'b0, NO_REPORT},
        '{1'b0, CH_DQUOTE, 1'b0, NO_REPORT},  // escaped quote
        '{1'b0, CH_NL,     1'b0, NO_REPORT},  // newline inside string
        '{1'b0, CH_RPAREN, 1'b0, NO_REPORT},
        '{1'b0, CH_DQUOTE, 1'b0, NO_REPORT},
        '{1'b0, CH_SQUOTE, 1'b0, NO_REPORT},
        '{1'b0, CH_DQUOTE, 1'b0, NO_REPORT},
        '{1'b0, CH_SQUOTE, 1'b0, NO_REPORT},
        '{1'b0, 8'h00,     1'b0, NO_REPORT},
        '{1'b0, CH_LPAREN, 1'b0, NO_REPORT},
        '{1'b0, CH_RPAREN, 1'b0, NO_REPORT},
        '{1'b0, CH_SLASH,  1'b0, NO_REPORT},
        '{1'b0, CH_RBRACE, 1'b0, NO_REPORT},  // lone slash then closer
        '{1'b1, 8'hFF,     1'b1,
          '{ERR_UNCLOSED, 16'd2, 16'd1, CH_LBRACE, CH_LBRACE, 16'd0, 1'b1}},
        '{1'b1, 8'h00,     1'b0, NO_REPORT}   // end of text on empty stack
    };

    function automatic void count_byte(logic [7:0] c);
        bit         is_closer;
        logic [1:0] code;
        is_closer = 1'b0;
        code      = BR_PAREN;
        if (col_now != POS_MAX) col_now++;
        mode = SCAN_NORMAL;
        case (c)
            CH_NL:
            begin
                if (line_now != POS_MAX) line_now++;
                col_now = 16'd0;
            end
            CH_SLASH: mode = SCAN_SLASH;
            CH_DQUOTE, CH_SQUOTE:
            begin
                mode         = SCAN_STRING;
                quote_single = (c == CH_SQUOTE);
                esc_pending  = 1'b0;
            end
            CH_LPAREN, CH_LBRACK, CH_LBRACE:
            begin
                if (depth < STACK_DEPTH)
                begin
                    stk_type[depth] = (c == CH_LPAREN) ? BR_PAREN :
                                      (c == CH_LBRACK) ? BR_BRACK : BR_BRACE;
                    stk_line[depth] = line_now;
                    stk_col[depth]  = col_now;
                    depth++;
                end
            end
            CH_RPAREN:
            begin
                is_closer = 1'b1;
                code      = BR_PAREN;
            end
            CH_RBRACK:
            begin
                is_closer = 1'b1;
                code      = BR_BRACK;
            end
            CH_RBRACE:
            begin
                is_closer = 1'b1;
                code      = BR_BRACE;
            end
            default: ;
        endcase
        if (is_closer)
        begin
            if (depth == 0)
                step_reports.push_back('{ERR_UNEXPECTED, line_now, col_now, c,
                                         8'h00, 16'd0, 1'b1});
            else
            begin
                depth--;
                if (stk_type[depth] != code)
                    step_reports.push_back('{ERR_MISMATCH, line_now, col_now, c,
                                             opener_chars[stk_type[depth]],
                                             stk_line[depth], 1'b1});
            end
        end
    endfunction

    function automatic void scan_item(logic eot, logic [7:0] c);
        logic [7:0] ob;
        step_reports.delete();
        if (eot)
        begin
            while (depth > 0)
            begin
                depth--;
                ob = opener_chars[stk_type[depth]];
                step_reports.push_back('{ERR_UNCLOSED, stk_line[depth], stk_col[depth],
                                         ob, ob, 16'd0, depth == 0});
            end
            line_now     = 16'd1;
            col_now      = 16'd0;
            mode         = SCAN_NORMAL;
            quote_single = 1'b0;
            esc_pending  = 1'b0;
        end
        else
        begin
            case (mode)
                SCAN_SLASH:
                begin
                    if (c == CH_SLASH) mode = SCAN_COMMENT;
                    else count_byte(c);
                end
                SCAN_COMMENT:
                begin
                    if (c == CH_NL) count_byte(c);
                end
                SCAN_STRING:
                begin
                    if (esc_pending) esc_pending = 1'b0;
                    else if (c == CH_BSLASH) esc_pending = 1'b1;
                    else if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) mode = SCAN_NORMAL;
                end
                default: count_byte(c);
            endcase
        end
    endfunction

    // called and returns at a falling edge; predicts at the accepting edge
    task automatic send_word(input logic eot, input logic [7:0] c,
                             input bit typed = 1'b0, input report_t want = '0);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= eot;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        scan_item(eot, c);
        if (typed) due_reports.push_back(want);
        else foreach (step_reports[i]) due_reports.push_back(step_reports[i]);
        sent_items++;
        if (eot) eot_items++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin : check_reports
        report_t got;
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[1:0], m_tdata[17:2], m_tdata[33:18], m_tdata[41:34],
                    m_tdata[49:42], m_tdata[65:50], m_tlast};
            seen_reports++;
            if (got.kind <= ERR_UNCLOSED) kind_seen[got.kind]++;
            if (due_reports.size() == 0)
            begin
                if (mismatches < 10)
                    $display("report with none pending: kind %0d line %0d col %0d found %h",
                             got.kind, got.line, got.col, got.found);
                mismatches++;
            end
            else
            begin
                want = due_reports.pop_front();
                if (got != want)
                begin
                    if (mismatches < 10)
                    begin
                        $display("bad report: exp kind %0d line %0d col %0d found %h open %h oline %0d last %b",
                                 want.kind, want.line, want.col, want.found, want.opener,
                                 want.oline, want.last);
                        $display("            got kind %0d line %0d col %0d found %h open %h oline %0d last %b",
                                 got.kind, got.line, got.col, got.found, got.opener,
                                 got.oline, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d reports pending",
                     quiet_cycles, due_reports.size());
            $display("bracket_balance_checker_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int         rand_start;
        int         r;
        int         n;
        logic [7:0] q;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].eot, directed_rows[i].ch,
                      directed_rows[i].typed, directed_rows[i].want);

        // extremes: full stack with drops, then a full flush
        no_idle = 1'b1;
        repeat (STACK_DEPTH + 6) send_word(1'b0, opener_chars[$urandom_range(2)]);
        send_word(1'b1, 8'hA5);
        no_idle = 1'b0;

        rand_start = sent_items;
        while (sent_items < rand_start + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 22)
                send_word(1'b0, opener_chars[$urandom_range(2)]);
            else if (r < 40)
            begin
                if (depth > 0 && $urandom_range(3) != 0)
                    send_word(1'b0, closer_chars[stk_type[depth-1]]);
                else
                    send_word(1'b0, closer_chars[$urandom_range(2)]);
            end
            else if (r < 52)
                send_word(1'b0, CH_NL);
            else if (r < 67)
                send_word(1'b0, 8'($urandom_range(255)));
            else if (r < 75)
            begin
                send_word(1'b0, CH_SLASH);
                send_word(1'b0, CH_SLASH);
                repeat ($urandom_range(6)) send_word(1'b0, 8'($urandom_range(255)));
                send_word(1'b0, CH_NL);
            end
            else if (r < 85)
            begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                send_word(1'b0, q);
                repeat ($urandom_range(6))
                begin
                    n = $urandom_range(3);
                    if (n == 0)
                    begin
                        send_word(1'b0, CH_BSLASH);
                        send_word(1'b0, 8'($urandom_range(255)));
                    end
                    else if (n == 1)
                        send_word(1'b0, (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
                    else
                        send_word(1'b0, 8'($urandom_range(255)));
                end
                send_word(1'b0, q);
            end
            else if (r < 90)
            begin
                send_word(1'b0, CH_SLASH);
                send_word(1'b0, closer_chars[$urandom_range(2)]);
            end
            else if (r < 97)
                send_word(1'b1, 8'($urandom_range(255)));
            else
            begin
                // deep nesting, now and then past the stack capacity
                n = ($urandom_range(3) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 12);
                repeat (n) send_word(1'b0, opener_chars[$urandom_range(2)]);
                send_word(1'b1, 8'($urandom_range(255)));
            end
            // a long run with both sides always ready
            no_idle = (sent_items - rand_start > 150) && (sent_items - rand_start < 240);
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (due_reports.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);

        $display("sent %0d words (%0d end of text), incl. directed rows and a stack-full run",
                 sent_items, eot_items);
        $display("checked %0d reports: %0d unexpected, %0d mismatched, %0d unclosed; %0d bad",
                 seen_reports, kind_seen[0], kind_seen[1], kind_seen[2], mismatches);
        if (mismatches == 0 && due_reports.size() == 0)
            $display("bracket_balance_checker_top: match");
        else
            $display("bracket_balance_checker_top: mismatch");
        $finish;
    end

endmodule
